[src/bpd_pkg.sv]
// bpd_pkg: shared types and constants of the bmp palette pixel decoder
// no dependencies; imported by the interfaces and every module of the block but bpd_ram

package bpd_pkg;

  // palette memory
  localparam int unsigned PAL_DEPTH = 256;
  localparam int unsigned PAL_AW    = $clog2(PAL_DEPTH);
  localparam int unsigned RGB_W     = 24;

  // field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 12;
  localparam int unsigned CODE_W = 3;

  // queue between parser and output stage
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned Q_AW   = $clog2(QDEPTH);
  localparam int unsigned Q_CW   = $clog2(QDEPTH + 1);

  // "BM" read little endian
  localparam logic [15:0] BMP_SIG = 16'd19778;

  // result kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef enum logic [CODE_W-1:0] {
    ERR_SIGNATURE = 3'd0,
    ERR_PLANES    = 3'd1,
    ERR_DEPTH     = 3'd2,
    ERR_COMPRESS  = 3'd3,
    ERR_HDR_SIZE  = 3'd4,
    ERR_DIMS      = 3'd5
  } bpd_err_t;

  // header byte positions at which a field is complete
  localparam logic [5:0] HB_SIG     = 6'd1;
  localparam logic [5:0] HB_HSIZE   = 6'd17;
  localparam logic [5:0] HB_WIDTH   = 6'd21;
  localparam logic [5:0] HB_HEIGHT  = 6'd25;
  localparam logic [5:0] HB_PLANES  = 6'd27;
  localparam logic [5:0] HB_DEPTH   = 6'd29;
  localparam logic [5:0] HB_COMPR   = 6'd33;
  localparam logic [5:0] HB_COLORS  = 6'd49;
  localparam logic [5:0] HB_END     = 6'd53;

  typedef struct packed {
    logic              kind;
    logic [CODE_W-1:0] error_code;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  column;
    logic              last_pixel;
  } bpd_item_t;

  typedef struct packed {
    logic      valid;
    bpd_item_t item;
  } bpd_push_t;

endpackage

[src/bpd_if.sv]
// bpd_in_if and bpd_out_if: valid/ready channels of the decoder
// depends on bpd_pkg for field widths

interface bpd_in_if import bpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              start_req;

  modport source (output valid, output data_byte, output start_req, input ready);
  modport sink (input valid, input data_byte, input start_req, output ready);
endinterface

interface bpd_out_if import bpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [CODE_W-1:0] error_code;
  logic [BYTE_W-1:0] red;
  logic [BYTE_W-1:0] green;
  logic [BYTE_W-1:0] blue;
  logic [POS_W-1:0]  row;
  logic [POS_W-1:0]  column;
  logic              last_pixel;

  modport source (output valid, output kind, output error_code, output red, output green,
                  output blue, output row, output column, output last_pixel, input ready);
  modport sink (input valid, input kind, input error_code, input red, input green,
                input blue, input row, input column, input last_pixel, output ready);
endinterface

[src/bmp_palette_pixel_decoder.sv]
// bmp_palette_pixel_decoder: top level of the 8-bit palette bmp decoder
// depends on bpd_pkg, bpd_in_if, bpd_out_if, bpd_front and bpd_back
//
// channel  | dir | payload                                         | transfer when
// ---------+-----+-------------------------------------------------+------------------
// in_ch    | in  | data_byte, start_req                            | valid && ready
// out_ch   | out | kind, error_code, red, green, blue, row, column,| valid && ready
//          |     | last_pixel                                      |
//
// one byte per cycle is taken while ready is high; counter and field work run on accept
// a pixel result reaches out_ch from its byte through palette read, queue and output reg
// synchronous active low reset returns the parser to idle and empties the queue
// the four-entry queue absorbs output stalls; in_ch.ready drops only when the queue
// plus the item in the palette read stage would fill it
// no clearing pass: palette entries are always written before a pixel can read them

module bmp_palette_pixel_decoder import bpd_pkg::*; #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  bpd_in_if.sink    in_ch,
  bpd_out_if.source out_ch
);

  // parser to queue push and queue fill level back
  bpd_push_t       push;
  logic [Q_CW-1:0] q_count;

  // front: header checks, palette load, pixel index lookup
  bpd_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_count (q_count),
    .push    (push)
  );

  // back: short queue and the output register that faces out_ch
  bpd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .q_count (q_count),
    .out_ch  (out_ch)
  );

endmodule

[src/bpd_ram.sv]
// bpd_ram: generic single write port, single read port ram with registered read
// no dependencies

module bpd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/bpd_front.sv]
// bpd_front: byte parser, header checks, palette load and pixel lookup issue
// depends on bpd_pkg, bpd_in_if and bpd_ram

module bpd_front import bpd_pkg::*; #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic            clk,
  input  logic            rst_n,
  bpd_in_if.sink          in_ch,
  input  logic [Q_CW-1:0] q_count,
  output bpd_push_t       push
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PALETTE,
    PH_PIXELS,
    PH_PAD
  } phase_t;

  phase_t            phase_r, phase_nxt, eff_phase;
  logic [5:0]        hc_r, hc_nxt, eff_hc;
  logic [31:0]       fs_r, fs_nxt, eff_fs, fs_new;
  logic [12:0]       width_r, width_nxt;
  logic [12:0]       height_r, height_nxt;
  logic [8:0]        count_r, count_nxt;
  logic              size_bad_r, size_bad_nxt, eff_size_bad;
  logic              dims_bad_r, dims_bad_nxt, eff_dims_bad;
  logic [8:0]        pal_idx_r, pal_idx_nxt;
  logic [1:0]        entry_r, entry_nxt;
  logic [BYTE_W-1:0] b0_r, b0_nxt, b1_r, b1_nxt;
  logic [POS_W-1:0]  row_r, row_nxt, col_r, col_nxt;
  logic [1:0]        pad_r, pad_nxt, pad_dec, pad_amt;

  // lookup stage waiting for palette read data
  logic              p1_valid_r, p1_valid_nxt;
  logic              p1_kind_r, p1_kind_nxt;
  logic [CODE_W-1:0] p1_code_r, p1_code_nxt;
  logic              p1_black_r, p1_black_nxt;
  logic [POS_W-1:0]  p1_row_r, p1_row_nxt, p1_col_r, p1_col_nxt;
  logic              p1_last_r, p1_last_nxt;

  logic              in_ready, accept, start;
  logic [15:0]       hi;
  logic [12:0]       col_plus;
  logic [8:0]        idx_plus;
  logic              end_of_row;
  logic [BYTE_W-1:0] b;

  logic              wr_en, rd_en;
  logic [RGB_W-1:0]  rd_data;

  function automatic logic dim_ok(input logic [31:0] v);
    return (v != 32'd0) && (v <= 32'(MAX_DIM));
  endfunction

  // space is held back for the item in the lookup stage
  assign in_ready    = (q_count + Q_CW'(p1_valid_r)) < Q_CW'(QDEPTH);
  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;
  assign start       = in_ch.start_req;
  assign b           = in_ch.data_byte;

  assign eff_phase    = start ? PH_HEADER : phase_r;
  assign eff_hc       = start ? 6'd0 : hc_r;
  assign eff_fs       = start ? 32'd0 : fs_r;
  assign eff_size_bad = start ? 1'b0 : size_bad_r;
  assign eff_dims_bad = start ? 1'b0 : dims_bad_r;
  assign fs_new       = {b, eff_fs[31:8]};
  assign hi           = fs_new[31:16];
  assign col_plus     = {1'b0, col_r} + 13'd1;
  assign end_of_row   = col_plus >= width_r;
  assign idx_plus     = pal_idx_r + 9'd1;
  assign pad_amt      = 2'(3'd4 - {1'b0, width_r[1:0]});
  assign pad_dec      = pad_r - 2'd1;

  always_comb begin
    phase_nxt    = phase_r;
    hc_nxt       = hc_r;
    fs_nxt       = fs_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    count_nxt    = count_r;
    size_bad_nxt = size_bad_r;
    dims_bad_nxt = dims_bad_r;
    pal_idx_nxt  = pal_idx_r;
    entry_nxt    = entry_r;
    b0_nxt       = b0_r;
    b1_nxt       = b1_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    pad_nxt      = pad_r;
    p1_valid_nxt = 1'b0;
    p1_kind_nxt  = KIND_PIXEL;
    p1_code_nxt  = '0;
    p1_black_nxt = 1'b0;
    p1_row_nxt   = '0;
    p1_col_nxt   = '0;
    p1_last_nxt  = 1'b0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;

    if (accept) begin
      if (start) begin
        width_nxt  = '0;
        height_nxt = '0;
        count_nxt  = '0;
      end
      phase_nxt    = eff_phase;
      hc_nxt       = eff_hc;
      fs_nxt       = eff_fs;
      size_bad_nxt = eff_size_bad;
      dims_bad_nxt = eff_dims_bad;

      unique case (eff_phase)
        PH_HEADER: begin
          fs_nxt = fs_new;
          hc_nxt = eff_hc + 6'd1;
          unique case (eff_hc)
            HB_SIG: begin
              if (hi != BMP_SIG) begin
                p1_valid_nxt = 1'b1;
                p1_kind_nxt  = KIND_ERROR;
                p1_code_nxt  = ERR_SIGNATURE;
                phase_nxt    = PH_IDLE;
              end
            end
            HB_HSIZE: size_bad_nxt = (fs_new != 32'd40);
            HB_WIDTH: begin
              if (dim_ok(fs_new)) begin
                width_nxt = fs_new[12:0];
              end else begin
                width_nxt    = '0;
                dims_bad_nxt = 1'b1;
              end
            end
            HB_HEIGHT: begin
              if (dim_ok(fs_new)) begin
                height_nxt = fs_new[12:0];
              end else begin
                height_nxt   = '0;
                dims_bad_nxt = 1'b1;
              end
            end
            HB_PLANES: begin
              if (hi != 16'd1) begin
                p1_valid_nxt = 1'b1;
                p1_kind_nxt  = KIND_ERROR;
                p1_code_nxt  = ERR_PLANES;
                phase_nxt    = PH_IDLE;
              end
            end
            HB_DEPTH: begin
              if (hi != 16'd8) begin
                p1_valid_nxt = 1'b1;
                p1_kind_nxt  = KIND_ERROR;
                p1_code_nxt  = ERR_DEPTH;
                phase_nxt    = PH_IDLE;
              end
            end
            HB_COMPR: begin
              if (fs_new != 32'd0) begin
                p1_valid_nxt = 1'b1;
                p1_kind_nxt  = KIND_ERROR;
                p1_code_nxt  = ERR_COMPRESS;
                phase_nxt    = PH_IDLE;
              end
            end
            HB_COLORS: begin
              if (fs_new == 32'd0) begin
                count_nxt = 9'(PAL_DEPTH);
              end else if (fs_new > 32'(PAL_DEPTH)) begin
                count_nxt    = '0;
                dims_bad_nxt = 1'b1;
              end else begin
                count_nxt = fs_new[8:0];
              end
            end
            HB_END: begin
              if (eff_size_bad) begin
                p1_valid_nxt = 1'b1;
                p1_kind_nxt  = KIND_ERROR;
                p1_code_nxt  = ERR_HDR_SIZE;
                phase_nxt    = PH_IDLE;
              end else if (eff_dims_bad) begin
                p1_valid_nxt = 1'b1;
                p1_kind_nxt  = KIND_ERROR;
                p1_code_nxt  = ERR_DIMS;
                phase_nxt    = PH_IDLE;
              end else begin
                phase_nxt   = PH_PALETTE;
                pal_idx_nxt = '0;
                entry_nxt   = '0;
              end
            end
            default: ;
          endcase
        end
        PH_PALETTE: begin
          entry_nxt = entry_r + 2'd1;
          unique case (entry_r)
            2'd0: b0_nxt = b;
            2'd1: b1_nxt = b;
            2'd2: wr_en = 1'b1;
            default: begin
              // pad byte of the entry closes it
              pal_idx_nxt = idx_plus;
              if (idx_plus >= count_r) begin
                phase_nxt = PH_PIXELS;
                row_nxt   = POS_W'(height_r - 13'd1);
                col_nxt   = '0;
              end
            end
          endcase
        end
        PH_PIXELS: begin
          rd_en        = 1'b1;
          p1_valid_nxt = 1'b1;
          p1_kind_nxt  = KIND_PIXEL;
          p1_black_nxt = {1'b0, b} >= count_r;
          p1_row_nxt   = row_r;
          p1_col_nxt   = col_r;
          p1_last_nxt  = end_of_row && (row_r == '0);
          if (end_of_row) begin
            if (row_r == '0) begin
              phase_nxt = PH_IDLE;
            end else if (pad_amt == 2'd0) begin
              row_nxt = row_r - POS_W'(1);
              col_nxt = '0;
            end else begin
              pad_nxt   = pad_amt;
              phase_nxt = PH_PAD;
            end
          end else begin
            col_nxt = col_plus[POS_W-1:0];
          end
        end
        PH_PAD: begin
          pad_nxt = pad_dec;
          if (pad_dec == 2'd0) begin
            row_nxt   = row_r - POS_W'(1);
            col_nxt   = '0;
            phase_nxt = PH_PIXELS;
          end
        end
        PH_IDLE: ;
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // control state takes the reset, the data path does not need it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      p1_valid_r <= 1'b0;
      hc_r       <= '0;
      size_bad_r <= 1'b0;
      dims_bad_r <= 1'b0;
      pal_idx_r  <= '0;
      entry_r    <= '0;
      pad_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      p1_valid_r <= p1_valid_nxt;
      hc_r       <= hc_nxt;
      size_bad_r <= size_bad_nxt;
      dims_bad_r <= dims_bad_nxt;
      pal_idx_r  <= pal_idx_nxt;
      entry_r    <= entry_nxt;
      pad_r      <= pad_nxt;
    end
    fs_r       <= fs_nxt;
    width_r    <= width_nxt;
    height_r   <= height_nxt;
    count_r    <= count_nxt;
    b0_r       <= b0_nxt;
    b1_r       <= b1_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    p1_kind_r  <= p1_kind_nxt;
    p1_code_r  <= p1_code_nxt;
    p1_black_r <= p1_black_nxt;
    p1_row_r   <= p1_row_nxt;
    p1_col_r   <= p1_col_nxt;
    p1_last_r  <= p1_last_nxt;
  end

  bpd_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PAL_DEPTH)
  ) u_palette (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pal_idx_r[PAL_AW-1:0]),
    .wr_data ({b, b1_r, b0_r}),
    .rd_en   (rd_en),
    .rd_addr (b),
    .rd_data (rd_data)
  );

  // palette colour joins the item as it enters the queue
  always_comb begin
    push.valid           = p1_valid_r;
    push.item.kind       = p1_kind_r;
    push.item.error_code = (p1_kind_r == KIND_ERROR) ? p1_code_r : '0;
    if ((p1_kind_r == KIND_ERROR) || p1_black_r) begin
      push.item.red   = '0;
      push.item.green = '0;
      push.item.blue  = '0;
    end else begin
      push.item.red   = rd_data[23:16];
      push.item.green = rd_data[15:8];
      push.item.blue  = rd_data[7:0];
    end
    push.item.row        = p1_row_r;
    push.item.column     = p1_col_r;
    push.item.last_pixel = p1_last_r;
  end

endmodule

[src/bpd_back.sv]
// bpd_back: result queue and output register of the decoder
// depends on bpd_pkg and bpd_out_if

module bpd_back import bpd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  bpd_push_t       push,
  output logic [Q_CW-1:0] q_count,
  bpd_out_if.source       out_ch
);

  bpd_item_t       q_mem [QDEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] count_r, count_nxt;
  logic            out_valid_r, out_valid_nxt;
  bpd_item_t       out_item_r;
  logic            pop;

  assign pop = (count_r != '0) && (!out_valid_r || out_ch.ready);

  always_comb begin
    wr_ptr_nxt    = push.valid ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt    = pop ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    count_nxt     = count_r + Q_CW'(push.valid) - Q_CW'(pop);
    out_valid_nxt = pop || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      q_mem[wr_ptr_r] <= push.item;
    end
    if (pop) begin
      out_item_r <= q_mem[rd_ptr_r];
    end
  end

  assign q_count           = count_r;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_item_r.kind;
  assign out_ch.error_code = out_item_r.error_code;
  assign out_ch.red        = out_item_r.red;
  assign out_ch.green      = out_item_r.green;
  assign out_ch.blue       = out_item_r.blue;
  assign out_ch.row        = out_item_r.row;
  assign out_ch.column     = out_item_r.column;
  assign out_ch.last_pixel = out_item_r.last_pixel;

endmodule
